[hdl/listed_object_step_limiter_unit_macros.svh]
// Assertion macros used by the checker file.
`ifndef LISTED_OBJECT_STEP_LIMITER_UNIT_MACROS_SVH
`define LISTED_OBJECT_STEP_LIMITER_UNIT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define LOSL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("step limiter check failed");

// Next-cycle implication, idle during reset.
`define LOSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("step limiter check failed");

`endif

[hdl/losl_pkg.sv]
// ----------------------------------------------------------------------------
// losl_pkg
// Types and constants of the listed object step limiter.
// ----------------------------------------------------------------------------
package losl_pkg;

  localparam int LIST_DEPTH    = 256;
  localparam int ADDR_W        = $clog2(LIST_DEPTH);
  localparam int CNT_W         = $clog2(LIST_DEPTH + 1);
  localparam int FRACTION_BITS = 16;

  // Serial step counts: 33-bit multiplier, 66-bit root, 33-bit quotient
  localparam int SER_STEPS = 33;
  localparam int STEP_W    = $clog2(SER_STEPS);

  localparam logic [32:0] EPS_FIX =
    33'(((64'd1 << FRACTION_BITS) + 64'd5000) / 64'd10000);

  localparam logic [15:0] FRAME_RESET   = 16'd1092;
  localparam logic [23:0] SPEED_RESET   = 24'(6 * (1 << FRACTION_BITS));
  localparam logic [30:0] MINSTEP_RESET = 31'(((2 << FRACTION_BITS) + 50) / 100);

  // Commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ADD     = 2'd1;
  localparam logic [1:0] CMD_REQUEST = 2'd2;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_SPEED    = 2'd1;
  localparam logic [1:0] CFG_MIN_STEP = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [15:0]        frame_time;
    logic [31:0]        object_handle;
    logic signed [31:0] current_x;
    logic signed [31:0] current_z;
    logic signed [31:0] wanted_x;
    logic signed [31:0] wanted_y;
    logic signed [31:0] wanted_z;
    logic signed [31:0] wanted_w;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               was_limited;
  } out_item_t;

endpackage

[hdl/listed_object_step_limiter_unit.sv]
// ----------------------------------------------------------------------------
// listed_object_step_limiter_unit
// Limits the horizontal step of listed objects per position request.
// ----------------------------------------------------------------------------
// Ticks, adds and unused commands give no result and leave the block idle. A
// request searches the handle table, reading and then comparing each stored
// entry in turn until a hit, then a listed request runs one shared
// bit-serial multiplier and a two-bit-a-cycle square root: the multiplier
// forms the limit and the two squares, the root follows, and each axis then
// takes a scaled multiply and a restoring divide before the output register
// is loaded. A listed request that is not shortened skips the multiplies and
// divides, and one that misses the table or skips the search goes straight
// to the output register. One item is worked on at a time; the next is taken
// once the result sits in the output register, and a stalled output holds a
// finished request until the previous result is taken.
module listed_object_step_limiter_unit
  import losl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CMP, S_LIM, S_SQX, S_SQZ, S_SQRT, S_MUL, S_DIV, S_DONE
  } state_t;

  state_t state_r;

  logic        enable_r;
  logic [23:0] speed_r;
  logic [30:0] min_step_r;
  logic [15:0] frame_r;
  logic [CNT_W-1:0] count_r;
  logic        ovf_r;

  logic [31:0] mem [LIST_DEPTH];
  logic [31:0] rd_data_r;
  logic [ADDR_W-1:0] idx_r;

  in_item_t  item_r;
  out_item_t out_r;
  logic      out_valid_r;

  logic [32:0] magx_r, magz_r;
  logic        negx_r, negz_r;
  logic [30:0] limit_r;
  logic        axis_r;

  logic [32:0] mul_a_r, mul_b_r;
  logic [65:0] acc_r;
  logic [65:0] sum_r;
  logic [65:0] rad_r;
  logic [34:0] rem_r;
  logic [32:0] root_r;
  logic [32:0] drem_r, dsh_r, quo_r;
  logic [STEP_W-1:0] step_r;

  logic [31:0] res_x_r, res_z_r;
  logic        lim_r;

  // Handshake
  logic in_acc, mem_we, last_step, out_free;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign last_step = (step_r == STEP_W'(SER_STEPS - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign mem_we    = in_acc && (in_data.command == CMD_ADD) &&
                     (in_data.object_handle != 32'd0) && !ovf_r &&
                     (count_r < CNT_W'(LIST_DEPTH));

  // Multiplier step: add multiplicand on set bit, shift right
  logic [33:0] mul_t;
  logic [65:0] acc_nxt;
  assign mul_t   = {1'b0, acc_r[65:33]} + (mul_b_r[0] ? {1'b0, mul_a_r} : 34'd0);
  assign acc_nxt = {mul_t, acc_r[32:1]};

  // Root step: two radicand bits a cycle
  logic [36:0] rem_t, trial;
  logic        root_ge;
  assign rem_t   = {rem_r, rad_r[65:64]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign root_ge = (rem_t >= trial);

  logic [34:0] rem_fin;
  logic [32:0] root_fin;
  assign rem_fin  = root_ge ? 35'(rem_t - trial) : rem_t[34:0];
  assign root_fin = {root_r[31:0], root_ge};

  logic gt_lim, gt_eps;
  assign gt_lim = (root_fin > {2'b00, limit_r}) ||
                  ((root_fin == {2'b00, limit_r}) && (rem_fin != 35'd0));
  assign gt_eps = (root_fin > EPS_FIX) || ((root_fin == EPS_FIX) && (rem_fin != 35'd0));

  // Divide step: one quotient bit a cycle
  logic [33:0] div_t;
  logic        div_ge;
  logic [32:0] quo_fin;
  assign div_t   = {drem_r, dsh_r[32]};
  assign div_ge  = (div_t >= {1'b0, root_r});
  assign quo_fin = {quo_r[31:0], div_ge};

  logic [31:0] off, cur, res;
  logic        neg;
  assign off = quo_fin[31:0];
  assign neg = axis_r ? negz_r : negx_r;
  assign cur = axis_r ? item_r.current_z : item_r.current_x;
  assign res = neg ? (cur - off) : (cur + off);

  // Signed differences for the hit
  logic [32:0] dx, dz;
  assign dx = {item_r.wanted_x[31], item_r.wanted_x} - {item_r.current_x[31], item_r.current_x};
  assign dz = {item_r.wanted_z[31], item_r.wanted_z} - {item_r.current_z[31], item_r.current_z};

  logic [23:0] lim_raw;
  assign lim_raw = acc_nxt[39:16];

  // Handle table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[ADDR_W-1:0]] <= in_data.object_handle;
    end
    rd_data_r <= mem[idx_r];
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b1;
      speed_r     <= SPEED_RESET;
      min_step_r  <= MINSTEP_RESET;
      frame_r     <= FRAME_RESET;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:   enable_r   <= cfg_data[0];
          CFG_SPEED:    speed_r    <= cfg_data[23:0];
          CFG_MIN_STEP: min_step_r <= cfg_data;
          default: ;
        endcase
      end
      // drop a taken item
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            item_r <= in_data;
            idx_r  <= '0;
            case (in_data.command)
              CMD_TICK: begin
                if (in_data.frame_time != 16'd0) frame_r <= in_data.frame_time;
                count_r <= '0;
                ovf_r   <= 1'b0;
              end
              CMD_ADD: begin
                if (in_data.object_handle != 32'd0 && !ovf_r) begin
                  if (count_r >= CNT_W'(LIST_DEPTH)) begin
                    count_r <= '0;
                    ovf_r   <= 1'b1;
                  end else begin
                    count_r <= count_r + 1'b1;
                  end
                end
              end
              CMD_REQUEST: begin
                res_x_r <= in_data.wanted_x;
                res_z_r <= in_data.wanted_z;
                lim_r   <= 1'b0;
                if (enable_r && in_data.object_handle != 32'd0 && !ovf_r &&
                    count_r != '0) begin
                  state_r <= S_RD;
                end else begin
                  state_r <= S_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: state_r <= S_CMP;
        S_CMP: begin
          if (rd_data_r == item_r.object_handle) begin
            negx_r  <= dx[32];
            magx_r  <= dx[32] ? (33'd0 - dx) : dx;
            negz_r  <= dz[32];
            magz_r  <= dz[32] ? (33'd0 - dz) : dz;
            mul_a_r <= {9'd0, speed_r};
            mul_b_r <= {17'd0, frame_r};
            acc_r   <= '0;
            step_r  <= '0;
            state_r <= S_LIM;
          end else if (({1'b0, idx_r} + 1'b1) == count_r) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_LIM, S_SQX, S_SQZ, S_MUL: begin
          acc_r  <= last_step ? '0 : acc_nxt;
          step_r <= last_step ? '0 : step_r + 1'b1;
          if (!last_step) begin
            mul_b_r <= mul_b_r >> 1;
          end else begin
            case (state_r)
              S_LIM: begin
                limit_r <= ({7'd0, lim_raw} < min_step_r) ? min_step_r : {7'd0, lim_raw};
                mul_a_r <= magx_r;
                mul_b_r <= magx_r;
                state_r <= S_SQX;
              end
              S_SQX: begin
                sum_r   <= acc_nxt;
                mul_a_r <= magz_r;
                mul_b_r <= magz_r;
                state_r <= S_SQZ;
              end
              S_SQZ: begin
                rad_r   <= sum_r + acc_nxt;
                rem_r   <= '0;
                root_r  <= '0;
                state_r <= S_SQRT;
              end
              default: begin
                drem_r  <= {2'b00, acc_nxt[63:33]};
                dsh_r   <= acc_nxt[32:0];
                quo_r   <= '0;
                state_r <= S_DIV;
              end
            endcase
          end
        end
        S_SQRT: begin
          rem_r  <= rem_fin;
          root_r <= root_fin;
          rad_r  <= rad_r << 2;
          step_r <= last_step ? '0 : step_r + 1'b1;
          if (last_step) begin
            if (gt_lim && gt_eps) begin
              axis_r  <= 1'b0;
              mul_a_r <= magx_r;
              mul_b_r <= {2'b00, limit_r};
              acc_r   <= '0;
              state_r <= S_MUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_DIV: begin
          drem_r <= div_ge ? 33'(div_t - {1'b0, root_r}) : div_t[32:0];
          dsh_r  <= dsh_r << 1;
          quo_r  <= quo_fin;
          step_r <= last_step ? '0 : step_r + 1'b1;
          if (last_step) begin
            if (!axis_r) begin
              res_x_r <= res;
              axis_r  <= 1'b1;
              mul_a_r <= magz_r;
              mul_b_r <= {2'b00, limit_r};
              acc_r   <= '0;
              state_r <= S_MUL;
            end else begin
              res_z_r <= res;
              lim_r   <= 1'b1;
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_r.out_x       <= res_x_r;
            out_r.out_y       <= item_r.wanted_y;
            out_r.out_z       <= res_z_r;
            out_r.out_w       <= item_r.wanted_w;
            out_r.was_limited <= lim_r;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hdl/losl_checker.sv]
// ----------------------------------------------------------------------------
// losl_checker
// Port-level checks of the step limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "listed_object_step_limiter_unit_macros.svh"

module losl_checker
  import losl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // held result stays
  `LOSL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `LOSL_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))
  // ticks, adds and unused commands finish at once
  `LOSL_ASSERT_NEXT(a_quick_cmd, in_acc && in_data.command != CMD_REQUEST, !in_stall)
  // a request occupies the block
  `LOSL_ASSERT_NEXT(a_req_busy, in_acc && in_data.command == CMD_REQUEST, in_stall)

endmodule

bind listed_object_step_limiter_unit losl_checker u_losl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
